// ===== design/xcr_pkg.sv =====
// Package for the XMODEM-CRC packet receiver.
// Holds result kind codes, framing bytes and CRC constants; no dependencies.
`default_nettype none

package xcr_pkg;

	typedef logic [1:0] kind_t;

	localparam kind_t KIND_DATA = 2'd0;
	localparam kind_t KIND_GOOD = 2'd1;
	localparam kind_t KIND_BAD  = 2'd2;
	localparam kind_t KIND_END  = 2'd3;

	localparam logic [7:0]  BYTE_SOH = 8'h01;
	localparam logic [7:0]  BYTE_EOT = 8'h04;
	localparam logic [7:0]  PAIR_OK  = 8'hFF;
	localparam logic [15:0] CRC_POLY = 16'h1021;

endpackage

`default_nettype wire

// ===== design/xcr_crc_byte.sv =====
// One-byte update of CRC-16/XMODEM (MSB first, no reflection).
// Pure XOR logic; depends on xcr_pkg for the polynomial.
`default_nettype none

module xcr_crc_byte
	import xcr_pkg::*;
(
	input  wire logic [15:0] crc_in,
	input  wire logic [7:0]  data,
	output logic      [15:0] crc_out
);

	always_comb begin
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int j = 0; j < 8; j++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_out = c;
	end

endmodule

`default_nettype wire

// ===== design/xmodem_crc_packet_receiver.sv =====
// XMODEM-CRC packet receiver: framing, block pair check and streaming CRC.
// Depends on xcr_pkg and xcr_crc_byte.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one serial byte per
//   transfer. Outside a packet, bytes other than SOH and EOT are dropped.
//   Output channel (out_valid/out_ready) carries kind, data_byte,
//   byte_index and block_number. Each payload byte is passed on with its
//   index; after the CRC low byte one good/bad report follows; EOT gives
//   an end-of-transfer report. Header and CRC high bytes give no result.
//   Latency: a result is valid in the cycle after its byte is transferred.
//   Throughput: one byte per cycle when unstalled, set by the single result
//   register; in_ready stays high while that register is empty or being drained.
//   When the output stalls, the result holds and in_ready drops until
//   it is taken. Reset returns the framer to idle with the CRC, counters
//   and block number cleared; no result is pending after reset.
`default_nettype none

module xmodem_crc_packet_receiver
	import xcr_pkg::*;
#(
	parameter int PACKET_BYTES = 128
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] rx_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [1:0]      kind,
	output logic [7:0]      data_byte,
	output logic [6:0]      byte_index,
	output logic [7:0]      block_number
);

	localparam int CW = $clog2(PACKET_BYTES + 1);
	localparam logic [CW-1:0] LAST_COUNT = CW'(PACKET_BYTES);

	localparam logic [2:0] PH_IDLE      = 3'd0;
	localparam logic [2:0] PH_BLOCK     = 3'd1;
	localparam logic [2:0] PH_BLOCK_INV = 3'd2;
	localparam logic [2:0] PH_DATA      = 3'd3;
	localparam logic [2:0] PH_CRC_HI    = 3'd4;
	localparam logic [2:0] PH_CRC_LO    = 3'd5;

	logic [2:0]    phase_q;
	logic [CW-1:0] count_q;
	logic [15:0]   crc_q;
	logic [7:0]    pair_sum_q;
	logic [7:0]    block_q;
	logic [7:0]    crc_hi_q;

	logic          out_valid_q;
	kind_t         kind_q;
	logic [7:0]    data_q;
	logic [6:0]    index_q;
	logic [7:0]    block_out_q;

	logic          take;
	logic [15:0]   crc_next;
	logic [CW-1:0] count_inc;
	logic [CW+6:0] count_ext;
	logic          emit;
	kind_t         emit_kind;
	logic          good;

	assign in_ready  = !out_valid_q || out_ready;
	assign take      = in_valid && in_ready;
	assign count_inc = count_q + CW'(1);
	assign count_ext = {7'd0, count_q};
	assign good      = ({crc_hi_q, rx_byte} == crc_q) && (pair_sum_q == PAIR_OK);

	xcr_crc_byte u_crc (
		.crc_in  (crc_q),
		.data    (rx_byte),
		.crc_out (crc_next)
	);

	always_comb begin
		emit      = 1'b0;
		emit_kind = KIND_DATA;
		case (phase_q)
			PH_DATA: begin
				emit = 1'b1;
			end
			PH_CRC_LO: begin
				emit      = 1'b1;
				emit_kind = good ? KIND_GOOD : KIND_BAD;
			end
			PH_IDLE: begin
				if (rx_byte == BYTE_EOT) begin
					emit      = 1'b1;
					emit_kind = KIND_END;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			count_q    <= '0;
			crc_q      <= '0;
			pair_sum_q <= '0;
			block_q    <= '0;
			crc_hi_q   <= '0;
		end else if (take) begin
			case (phase_q)
				PH_BLOCK: begin
					block_q    <= rx_byte;
					pair_sum_q <= rx_byte;
					phase_q    <= PH_BLOCK_INV;
				end
				PH_BLOCK_INV: begin
					pair_sum_q <= pair_sum_q + rx_byte;
					count_q    <= '0;
					crc_q      <= '0;
					phase_q    <= PH_DATA;
				end
				PH_DATA: begin
					crc_q   <= crc_next;
					count_q <= count_inc;
					if (count_inc == LAST_COUNT) begin
						phase_q <= PH_CRC_HI;
					end
				end
				PH_CRC_HI: begin
					crc_hi_q <= rx_byte;
					phase_q  <= PH_CRC_LO;
				end
				PH_CRC_LO: begin
					phase_q <= PH_IDLE;
				end
				default: begin
					phase_q <= (rx_byte == BYTE_SOH) ? PH_BLOCK : PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= emit;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			kind_q      <= emit_kind;
			data_q      <= (emit_kind == KIND_DATA) ? rx_byte : 8'd0;
			index_q     <= (emit_kind == KIND_DATA) ? count_ext[6:0] : 7'd0;
			block_out_q <= block_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign byte_index   = index_q;
	assign block_number = block_out_q;

`ifndef SYNTHESIS
	a_data_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_DATA |-> count_q < LAST_COUNT)
		else $error("payload count out of range");

	a_eot_report: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_IDLE && rx_byte == BYTE_EOT
		|=> out_valid && kind == KIND_END && phase_q == PH_IDLE)
		else $error("EOT not reported");

	a_crc_lo_report: assert property (@(posedge clk) disable iff (!arst_n)
		take && phase_q == PH_CRC_LO
		|=> out_valid && (kind == KIND_GOOD || kind == KIND_BAD) && phase_q == PH_IDLE)
		else $error("packet report missing");

	a_header_silent: assert property (@(posedge clk) disable iff (!arst_n)
		take && (phase_q == PH_BLOCK || phase_q == PH_BLOCK_INV || phase_q == PH_CRC_HI)
		|=> !out_valid)
		else $error("header byte produced a result");
`endif

endmodule

`default_nettype wire
